// ----- rtl/bdc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdc_pkg: shared constants and types for the Bezier curve evaluator
// Value formats, parameter formats and derived arithmetic widths used by the
// evaluator pipeline and its port checker.
// ---------------------------------------------------------------------------
package bdc_pkg;

   // Control values and the result are signed Q8.8.
   localparam int VALUE_BITS  = 16;
   // The curve parameter is unsigned Q0.16 plus one bit to hold 1.0.
   localparam int T_FRAC_BITS = 16;
   localparam int T_BITS      = T_FRAC_BITS + 1;

   // Number of control values per item and the highest supported degree.
   localparam int NUM_CTRL    = 7;
   localparam int MAX_DEGREE  = NUM_CTRL - 1;
   localparam int DEG_BITS    = 3;

   // Difference of two offset-binary values and its product with t.
   localparam int DIFF_BITS   = VALUE_BITS + 1;
   localparam int PROD_BITS   = DIFF_BITS + T_BITS + 1;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [T_BITS-1:0]     tparam_type;
   typedef logic [DEG_BITS-1:0]   degree_type;

   // t = 1.0 and the rounding constant of one interpolation.
   localparam tparam_type T_ONE    = tparam_type'(1 << T_FRAC_BITS);
   localparam int         T_HALF   = 1 << (T_FRAC_BITS - 1);

   // Degree register reset value and the legal degree bounds.
   localparam degree_type DEG_RESET = degree_type'(MAX_DEGREE);
   localparam degree_type DEG_MIN   = degree_type'(1);
   localparam degree_type DEG_MAX   = degree_type'(MAX_DEGREE);

endpackage : bdc_pkg

// ----- rtl/bezier_de_casteljau_eval.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bezier_de_casteljau_eval: pipelined Bezier curve coordinate evaluator
// Evaluates one coordinate of a Bezier curve of degree 1 to 6 at parameter t
// with de Casteljau's triangle of linear interpolations, one level of the
// triangle per pair of pipeline stages.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  req     | in        | req_valid/stall    | req_ctrl_0..6 (Q8.8), req_param_t
//  rsp     | out       | rsp_valid/stall    | rsp_curve_value (Q8.8)
//  csr     | in        | csr_valid/ready    | csr_curve_degree (3 bits)
//
//  Without a stall on rsp, one item per cycle enters through an input register
//  followed by a multiply stage and an add stage for each of the six levels.
//  The multiply stage of each level sets the clock period.
//  Every stage advances when it is empty or its successor advances, so
//  bubbles collapse and a stall on rsp holds everything without loss.
//  Synchronous reset clears the valid bits and sets the degree to 6.
//  csr_ready is always high; the degree travels with each item.
//
module bezier_de_casteljau_eval
   import bdc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // Input transfer channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_0,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_1,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_2,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_3,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_4,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_5,
   input  logic signed [VALUE_BITS-1:0] req_ctrl_6,
   input  logic        [T_BITS-1:0]     req_param_t,
   // Result transfer channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_curve_value,
   // Degree register write channel.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic        [DEG_BITS-1:0]   csr_curve_degree
);

   // Degree register.
   degree_type degree_ff;
   degree_type degree_clamp;

   // Interpolated values after each level; level 0 is the input register.
   value_type  val_ff   [0:MAX_DEGREE][0:NUM_CTRL-1];
   logic       vv_ff    [0:MAX_DEGREE];
   tparam_type vt_ff    [0:MAX_DEGREE-1];
   degree_type vdeg_ff  [0:MAX_DEGREE-1];
   logic       ven      [0:MAX_DEGREE];

   // Products and left operands held between multiply and add stages.
   logic signed [PROD_BITS-1:0] prod_ff [1:MAX_DEGREE][0:NUM_CTRL-1];
   value_type  base_ff  [1:MAX_DEGREE][0:NUM_CTRL-1];
   logic       mv_ff    [1:MAX_DEGREE];
   tparam_type mt_ff    [1:MAX_DEGREE-1];
   degree_type mdeg_ff  [1:MAX_DEGREE-1];
   logic       men      [1:MAX_DEGREE];

   // Input conversion: control values to offset binary, t and degree clamped.
   value_type  ctrl_in  [0:NUM_CTRL-1];
   tparam_type t_in;

   // The degree register accepts a transfer in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEG_RESET;
      end else if (csr_valid && csr_ready) begin
         degree_ff <= csr_curve_degree;
      end
   end

   // Degree zero acts as degree one and degree seven as degree six.
   always_comb begin
      if (degree_ff < DEG_MIN) begin
         degree_clamp = DEG_MIN;
      end else if (degree_ff > DEG_MAX) begin
         degree_clamp = DEG_MAX;
      end else begin
         degree_clamp = degree_ff;
      end
   end

   // Flipping the sign bit moves a signed value into offset binary.
   assign ctrl_in[0] = {~req_ctrl_0[VALUE_BITS-1], req_ctrl_0[VALUE_BITS-2:0]};
   assign ctrl_in[1] = {~req_ctrl_1[VALUE_BITS-1], req_ctrl_1[VALUE_BITS-2:0]};
   assign ctrl_in[2] = {~req_ctrl_2[VALUE_BITS-1], req_ctrl_2[VALUE_BITS-2:0]};
   assign ctrl_in[3] = {~req_ctrl_3[VALUE_BITS-1], req_ctrl_3[VALUE_BITS-2:0]};
   assign ctrl_in[4] = {~req_ctrl_4[VALUE_BITS-1], req_ctrl_4[VALUE_BITS-2:0]};
   assign ctrl_in[5] = {~req_ctrl_5[VALUE_BITS-1], req_ctrl_5[VALUE_BITS-2:0]};
   assign ctrl_in[6] = {~req_ctrl_6[VALUE_BITS-1], req_ctrl_6[VALUE_BITS-2:0]};

   // A parameter above 1.0 saturates to 1.0.
   assign t_in = (req_param_t > T_ONE) ? T_ONE : req_param_t;

   // Stage enables ripple back from the output: a stage moves when it is
   // empty or when the stage after it moves.
   assign ven[MAX_DEGREE] = !vv_ff[MAX_DEGREE] || !rsp_stall;

   for (genvar l = 1; l <= MAX_DEGREE; l++) begin : g_enable
      assign men[l]   = !mv_ff[l] || ven[l];
      assign ven[l-1] = !vv_ff[l-1] || men[l];
   end

   assign req_stall = !ven[0];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff[0] <= 1'b0;
      end else if (ven[0]) begin
         vv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ven[0]) begin
         for (int i = 0; i < NUM_CTRL; i++) begin
            val_ff[0][i] <= ctrl_in[i];
         end
         vt_ff[0]   <= t_in;
         vdeg_ff[0] <= degree_clamp;
      end
   end

   // One level of the triangle: a multiply stage and an add stage.
   for (genvar l = 1; l <= MAX_DEGREE; l++) begin : g_level

      logic                        level_on;
      logic signed [PROD_BITS-1:0] prod_in [0:NUM_CTRL-1];
      value_type                   val_in  [0:NUM_CTRL-1];

      // Levels above the item's degree pass value 0 through unchanged.
      assign level_on = (degree_type'(l) <= vdeg_ff[l-1]);

      for (genvar i = 0; i < NUM_CTRL; i++) begin : g_elem
         logic signed [PROD_BITS-1:0] sum_w;
         logic signed [PROD_BITS-1:0] shift_w;

         if (i < NUM_CTRL - l) begin : g_lerp
            logic signed [DIFF_BITS-1:0] diff_w;
            logic signed [PROD_BITS-1:0] mul_w;

            // a*(1-t) + b*t is rewritten as a + (b-a)*t.
            assign diff_w = $signed({1'b0, val_ff[l-1][i+1]})
                          - $signed({1'b0, val_ff[l-1][i]});
            assign mul_w  = diff_w * $signed({1'b0, vt_ff[l-1]});
            assign prod_in[i] = level_on ? mul_w : '0;
         end else begin : g_hold
            assign prod_in[i] = '0;
         end

         // Round, shift and add back the left operand; the convex
         // combination keeps the sum inside the value range.
         assign sum_w     = prod_ff[l][i] + $signed(PROD_BITS'(T_HALF));
         assign shift_w   = sum_w >>> T_FRAC_BITS;
         assign val_in[i] = base_ff[l][i] + shift_w[VALUE_BITS-1:0];
      end

      // Multiply stage.
      always_ff @(posedge clock) begin
         if (reset) begin
            mv_ff[l] <= 1'b0;
         end else if (men[l]) begin
            mv_ff[l] <= vv_ff[l-1];
         end
      end

      always_ff @(posedge clock) begin
         if (men[l]) begin
            for (int i = 0; i < NUM_CTRL; i++) begin
               prod_ff[l][i] <= prod_in[i];
               base_ff[l][i] <= val_ff[l-1][i];
            end
         end
      end

      // Add stage.
      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[l] <= 1'b0;
         end else if (ven[l]) begin
            vv_ff[l] <= mv_ff[l];
         end
      end

      always_ff @(posedge clock) begin
         if (ven[l]) begin
            for (int i = 0; i < NUM_CTRL; i++) begin
               val_ff[l][i] <= val_in[i];
            end
         end
      end

      // The parameter and degree ride along while later levels need them.
      if (l < MAX_DEGREE) begin : g_side
         always_ff @(posedge clock) begin
            if (men[l]) begin
               mt_ff[l]   <= vt_ff[l-1];
               mdeg_ff[l] <= vdeg_ff[l-1];
            end
         end

         always_ff @(posedge clock) begin
            if (ven[l]) begin
               vt_ff[l]   <= mt_ff[l];
               vdeg_ff[l] <= mdeg_ff[l];
            end
         end
      end
   end

   // The apex of the triangle, back from offset binary to signed.
   assign rsp_valid       = vv_ff[MAX_DEGREE];
   assign rsp_curve_value = {~val_ff[MAX_DEGREE][0][VALUE_BITS-1],
                             val_ff[MAX_DEGREE][0][VALUE_BITS-2:0]};

endmodule : bezier_de_casteljau_eval

// ----- rtl/bdc_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdc_checker: port-level checks for the Bezier curve evaluator
// Watches the evaluator's ports over time and reports violations of its
// reset, flow control and output hold behavior.
// ---------------------------------------------------------------------------
module bdc_checker
   import bdc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [VALUE_BITS-1:0] rsp_curve_value
);

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid in the cycle after reset");

   // The input only stalls when the output holds a result that is stalled.
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output is free");

   // An empty output stage means the whole pipeline can advance.
   a_accept_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output stage");

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_curve_value)))
      else $error("stalled result changed or dropped");

   // The input valid is never unknown outside reset.
   a_req_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_valid))
      else $error("input valid is unknown");

endmodule : bdc_checker

bind bezier_de_casteljau_eval bdc_checker u_bdc_checker (.*);

// ----- bench/bezier_de_casteljau_eval_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bezier_de_casteljau_eval_tb: self-checking bench for the Bezier evaluator
// Streams control values and curve parameters through the evaluator under
// several degree settings and traffic patterns. A scoreboard class predicts
// each curve value by de Casteljau's triangle and checks results in order.
// ---------------------------------------------------------------------------
module bezier_de_casteljau_eval_tb
   import bdc_pkg::*;
();

   // Traffic patterns for the two channels.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int PIPE_LATENCY   = 13;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ITEMS = 20;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 141;

   localparam value_type VALUE_MAX = value_type'(16'h7FFF);
   localparam value_type VALUE_MIN = value_type'(16'h8000);

   // Predicts curve values and holds them until the matching result arrives.
   class curve_value_checker;
      value_type predicted_curve_values[$];
      int        error_count;

      function new();
         error_count = 0;
      endfunction

      // De Casteljau's triangle in signed arithmetic with round-half-up.
      function value_type eval_curve_point(value_type ctrl[NUM_CTRL], tparam_type t,
                                           degree_type deg);
         longint pts[NUM_CTRL];
         longint weight;
         longint one;
         longint mix;
         int     order;
         int     lvl;
         int     i;
         one   = longint'(1) << T_FRAC_BITS;
         order = int'(deg);
         if (order < int'(DEG_MIN)) order = int'(DEG_MIN);
         if (order > int'(DEG_MAX)) order = int'(DEG_MAX);
         // A parameter above one saturates to t = 1.0.
         weight = longint'(t);
         if (weight > one) weight = one;
         for (i = 0; i < NUM_CTRL; i++) pts[i] = longint'($signed(ctrl[i]));
         for (lvl = 0; lvl < order; lvl++) begin
            for (i = 0; i < order - lvl; i++) begin
               mix    = pts[i] * (one - weight) + pts[i+1] * weight + longint'(T_HALF);
               pts[i] = mix >>> T_FRAC_BITS;
            end
         end
         return value_type'(pts[0]);
      endfunction

      function void note_sample(value_type ctrl[NUM_CTRL], tparam_type t, degree_type deg);
         predicted_curve_values.insert(predicted_curve_values.size(),
                                       eval_curve_point(ctrl, t, deg));
      endfunction

      function void check_curve_value(value_type actual);
         value_type wanted;
         if (predicted_curve_values.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, actual);
            error_count++;
         end else begin
            wanted = predicted_curve_values.pop_front();
            if (wanted !== actual) begin
               $display("%0t: curve_value mismatch, expected %h, actual %h",
                        $time, wanted, actual);
               error_count++;
            end
         end
      endfunction

      function int pending();
         return predicted_curve_values.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   value_type  req_ctrl [NUM_CTRL];
   tparam_type req_param_t;
   logic       rsp_valid;
   logic       rsp_stall;
   value_type  rsp_curve_value;
   logic       csr_valid;
   logic       csr_ready;
   degree_type csr_curve_degree;

   degree_type         degree_setting;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 quiet_cycles;
   curve_value_checker curve_check;

   bezier_de_casteljau_eval dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ctrl_0       (req_ctrl[0]),
      .req_ctrl_1       (req_ctrl[1]),
      .req_ctrl_2       (req_ctrl[2]),
      .req_ctrl_3       (req_ctrl[3]),
      .req_ctrl_4       (req_ctrl[4]),
      .req_ctrl_5       (req_ctrl[5]),
      .req_ctrl_6       (req_ctrl[6]),
      .req_param_t      (req_param_t),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_curve_value  (rsp_curve_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_curve_degree (csr_curve_degree)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Receiver stall pattern, redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // Transfer monitor: every accepted item, result and degree write.
   always @(posedge clock) begin
      if (reset) begin
         degree_setting <= DEG_RESET;
      end else begin
         if (req_valid && !req_stall) curve_check.note_sample(req_ctrl, req_param_t,
                                                               degree_setting);
         if (rsp_valid && !rsp_stall) curve_check.check_curve_value(rsp_curve_value);
         if (csr_valid && csr_ready) degree_setting <= csr_curve_degree;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("** bezier_de_casteljau_eval: FAILED **");
            $finish;
         end
      end
   end

   // Mostly full-range values, sometimes the extremes.
   function automatic value_type random_ctrl();
      case ($urandom_range(9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return ($urandom_range(1) == 1) ? value_type'(0) : value_type'(16'hFFFF);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Mostly t within [0, 1], with the ends and out-of-range values mixed in.
   function automatic tparam_type random_param();
      case ($urandom_range(15))
         0: return tparam_type'(0);
         1: return T_ONE;
         2: return tparam_type'($urandom_range(65537, 131071));
         3: return tparam_type'($urandom_range(1, 3));
         4: return tparam_type'(65535);
         default: return tparam_type'($urandom_range(0, 65536));
      endcase
   endfunction

   // Present one item at the falling edge and hold it until it is accepted.
   task automatic send_item(input value_type ctrl[NUM_CTRL], input tparam_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_ctrl    = ctrl;
      req_param_t = t;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Wait for every outstanding result before touching the degree register.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (curve_check.pending() != 0) @(negedge clock);
   endtask

   task automatic write_degree(input degree_type deg);
      wait_drained();
      csr_valid        = 1'b1;
      csr_curve_degree = deg;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 88;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 88;
         end
         default: begin
            send_idle_pct  = 7;
            recv_stall_pct = 7;
         end
      endcase
   endtask

   // Main sequence: reset, directed corners, then random phases.
   initial begin
      value_type     ctrl [NUM_CTRL];
      tparam_type    corner_t [10];
      degree_type    phase_degree [PHASE_COUNT];
      idle_mode_type mode;
      int            k;
      int            i;

      corner_t     = '{0, 1, 32768, 65535, 65536, 65537, 131071, 16384, 49152, 2};
      phase_degree = '{1, 6, 0, 7, 2, 5, 3, 4};

      curve_check      = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ctrl         = '{default: '0};
      req_param_t      = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_curve_degree = DEG_RESET;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      degree_setting   = DEG_RESET;
      quiet_cycles     = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners at the reset degree: full-scale values and edge t.
      for (k = 0; k < DIRECTED_ITEMS; k++) begin
         for (i = 0; i < NUM_CTRL; i++) begin
            case (k % 5)
               0: ctrl[i] = VALUE_MAX;
               1: ctrl[i] = VALUE_MIN;
               2: ctrl[i] = (i % 2 == 0) ? VALUE_MAX : VALUE_MIN;
               3: ctrl[i] = (i % 2 == 0) ? VALUE_MIN : VALUE_MAX;
               default: ctrl[i] = value_type'($urandom);
            endcase
         end
         send_item(ctrl, corner_t[k % 10]);
      end

      // Random phases; degrees zero and seven exercise the clamping.
      for (k = 0; k < PHASE_COUNT; k++) begin
         write_degree(phase_degree[k]);
         mode = idle_mode_type'(k % 4);
         set_idling(mode);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            for (i = 0; i < NUM_CTRL; i++) ctrl[i] = random_ctrl();
            send_item(ctrl, random_param());
         end
      end

      // Drain the pipeline, then keep the clock running to catch stray results.
      set_idling(IDLE_NONE);
      wait_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      if (curve_check.error_count == 0 && curve_check.pending() == 0) begin
         $display("** bezier_de_casteljau_eval: PASSED **");
      end else begin
         $display("** bezier_de_casteljau_eval: FAILED **");
      end
      $finish;
   end

endmodule : bezier_de_casteljau_eval_tb

// ----- bezier_de_casteljau_eval.f -----
rtl/bdc_pkg.sv
rtl/bezier_de_casteljau_eval.sv
rtl/bdc_checker.sv
bench/bezier_de_casteljau_eval_tb.sv
